FILE: design/dsop_pkg.sv
// Shared types and constants for the distributed-clock sync offset controller.
`default_nettype none

package dsop_pkg;

	// Field widths.
	localparam int TIME_W = 63;
	localparam int CYC_W  = 30;
	localparam int OFS_W  = 32;
	localparam int PH_W   = 31;
	localparam int INT_W  = 32;
	localparam int PROD_W = 64;

	// Remainder iteration count and its counter width.
	localparam int REM_STEPS = TIME_W;
	localparam int CNT_W     = $clog2(REM_STEPS);

	// Fixed sync shift and reset cycle time in nanoseconds.
	localparam logic [TIME_W-1:0] SYNC_SHIFT_NS = TIME_W'(50000);
	localparam logic [CYC_W-1:0]  CYCLE_RESET   = CYC_W'(1000000);

	// Reciprocals for the truncating divisions by 100 and by 20.
	// The quotient of x is (x * M) >> K, exact for the operand ranges used here.
	localparam int               ERR_DIV_SHIFT = 37;
	localparam logic [31:0]      ERR_DIV_MULT  = 32'd1374389535;
	localparam int               INT_DIV_SHIFT = 36;
	localparam logic [31:0]      INT_DIV_MULT  = 32'd3435973837;

	// Integrator limits.
	localparam logic signed [INT_W-1:0] INT_MAX = 32'sh7fffffff;
	localparam logic signed [INT_W-1:0] INT_MIN = 32'sh80000000;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_REM,
		ST_WRAP,
		ST_MUL_E,
		ST_MUL_I,
		ST_OUT
	} state_t;

	// Constant selected for the shared multiplier.
	typedef enum logic {
		MUL_ERR,
		MUL_INT
	} mul_sel_t;

	// Multiplier request from the sequencer.
	typedef struct packed {
		logic     en;
		mul_sel_t sel;
	} mul_req_t;

	// Remainder unit status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic last;
	} rem_status_t;

endpackage

`default_nettype wire

FILE: design/dsop_rem.sv
// Radix-2 restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module dsop_rem (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [dsop_pkg::TIME_W-1:0] dividend,
	input  wire logic [dsop_pkg::CYC_W-1:0]  divisor,
	output dsop_pkg::rem_status_t           status,
	output logic [dsop_pkg::CYC_W-1:0]       remainder
);

	logic [dsop_pkg::TIME_W-1:0] num_q;
	logic [dsop_pkg::CYC_W-1:0]  rem_q;
	logic [dsop_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic [dsop_pkg::CYC_W:0]    trial;
	logic [dsop_pkg::CYC_W:0]    diff;
	logic [dsop_pkg::CYC_W-1:0]  rem_next;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial    = {rem_q, num_q[dsop_pkg::TIME_W-1]};
		diff     = trial - {1'b0, divisor};
		rem_next = (trial >= {1'b0, divisor}) ? diff[dsop_pkg::CYC_W-1:0]
		                                      : trial[dsop_pkg::CYC_W-1:0];
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= dsop_pkg::CNT_W'(dsop_pkg::REM_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[dsop_pkg::TIME_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign status.busy = busy_q;
	assign status.last = busy_q && (cnt_q == '0);
	assign remainder   = rem_q;

endmodule

`default_nettype wire

FILE: design/dsop_cmul.sv
// Shared constant multiplier for the reciprocal divisions, registered product.
`default_nettype none

module dsop_cmul (
	input  wire logic                        clk,
	input  wire dsop_pkg::mul_req_t          req,
	input  wire logic [31:0]                 operand,
	output logic [dsop_pkg::PROD_W-1:0]      product
);

	logic [31:0]                 mult;
	logic [dsop_pkg::PROD_W-1:0] product_q;

	// Pick the reciprocal for the requested division.
	always_comb begin
		case (req.sel)
			dsop_pkg::MUL_ERR: mult = dsop_pkg::ERR_DIV_MULT;
			dsop_pkg::MUL_INT: mult = dsop_pkg::INT_DIV_MULT;
			default:           mult = dsop_pkg::ERR_DIV_MULT;
		endcase
	end

	// One 32 by 32 multiply per request.
	always_ff @(posedge clk) begin
		if (req.en) begin
			product_q <= {32'd0, operand} * {32'd0, mult};
		end
	end

	assign product = product_q;

endmodule

`default_nettype wire

FILE: design/dc_sync_offset_pi.sv
// Top level of the distributed-clock sync offset controller with sequencer.
//
//  Channel   Direction  Signals                               Handshake
//  input     in         reference_time                        in_valid / in_stall
//  output    out        offset_time, phase_error              out_valid / out_stall
//  config    in         cfg_data                              cfg_we
//
// A request passes from acceptance to out_valid through a setup state, the
// bit-serial remainder unit, a wrap state, the shared multiplier states ST_MUL_E
// and ST_MUL_I and an output state; with a zero cycle time the remainder unit
// is skipped. in_stall is high from the cycle after acceptance until the result
// is loaded into the output register, so a new request waits until the last
// one is loaded. Reset clears the integrator, restores the default cycle time
// and empties the output register. A stalled result holds the output register;
// the next request may be accepted while it waits.
`default_nettype none

module dc_sync_offset_pi (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [dsop_pkg::CYC_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [dsop_pkg::TIME_W-1:0]       reference_time,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [dsop_pkg::OFS_W-1:0]      offset_time,
	output logic signed [dsop_pkg::PH_W-1:0]       phase_error
);

	dsop_pkg::state_t      state_q, state_d;
	dsop_pkg::rem_status_t rem_status;
	dsop_pkg::mul_req_t    mul_req;

	logic [dsop_pkg::CYC_W-1:0]        cycle_q;
	logic [dsop_pkg::TIME_W-1:0]       time_q;
	logic [dsop_pkg::TIME_W-1:0]       mag;
	logic                              time_ge;
	logic                              neg_q;
	logic                              rem_start;
	logic [dsop_pkg::CYC_W-1:0]        rem_val;
	logic [dsop_pkg::CYC_W-1:0]        half;
	logic signed [dsop_pkg::PH_W-1:0]  err_d;
	logic [dsop_pkg::CYC_W-1:0]        eabs_d;
	logic                              eneg_d;
	logic                              epos_d;
	logic signed [dsop_pkg::PH_W-1:0]  err_q;
	logic [dsop_pkg::CYC_W-1:0]        eabs_q;
	logic                              eneg_q;
	logic signed [dsop_pkg::INT_W-1:0] integ_q;
	logic [31:0]                       iabs;
	logic                              ineg_q;
	logic [31:0]                       mul_operand;
	logic [dsop_pkg::PROD_W-1:0]       product;
	logic [dsop_pkg::PROD_W-dsop_pkg::ERR_DIV_SHIFT-1:0] qe_q;
	logic [dsop_pkg::PROD_W-dsop_pkg::INT_DIV_SHIFT-1:0] qi;
	logic [dsop_pkg::OFS_W-1:0]        se;
	logic [dsop_pkg::OFS_W-1:0]        si;
	logic [dsop_pkg::OFS_W-1:0]        ofs;
	logic                              in_take;
	logic                              out_load;
	logic                              out_valid_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q <= dsop_pkg::CYCLE_RESET;
		end else if (cfg_we) begin
			cycle_q <= cfg_data;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dsop_pkg::ST_IDLE:  if (in_valid) state_d = dsop_pkg::ST_PREP;
			dsop_pkg::ST_PREP:  state_d = (cycle_q == '0) ? dsop_pkg::ST_WRAP : dsop_pkg::ST_REM;
			dsop_pkg::ST_REM:   if (rem_status.last) state_d = dsop_pkg::ST_WRAP;
			dsop_pkg::ST_WRAP:  state_d = dsop_pkg::ST_MUL_E;
			dsop_pkg::ST_MUL_E: state_d = dsop_pkg::ST_MUL_I;
			dsop_pkg::ST_MUL_I: state_d = dsop_pkg::ST_OUT;
			dsop_pkg::ST_OUT:   if (!out_valid_q || !out_stall) state_d = dsop_pkg::ST_IDLE;
			default:            state_d = dsop_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall    = 1'b1;
		rem_start   = 1'b0;
		mul_req.en  = 1'b0;
		mul_req.sel = dsop_pkg::MUL_ERR;
		out_load    = 1'b0;
		case (state_q)
			dsop_pkg::ST_IDLE:  in_stall = 1'b0;
			dsop_pkg::ST_PREP:  rem_start = (cycle_q != '0);
			dsop_pkg::ST_MUL_E: mul_req.en = 1'b1;
			dsop_pkg::ST_MUL_I: begin
				mul_req.en  = 1'b1;
				mul_req.sel = dsop_pkg::MUL_INT;
			end
			dsop_pkg::ST_OUT:   out_load = !out_valid_q || !out_stall;
			default:            in_stall = 1'b1;
		endcase
	end

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsop_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Magnitude and sign of the shifted reference time.
	always_comb begin
		time_ge = time_q >= dsop_pkg::SYNC_SHIFT_NS;
		mag     = time_ge ? (time_q - dsop_pkg::SYNC_SHIFT_NS)
		                  : (dsop_pkg::SYNC_SHIFT_NS - time_q);
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			time_q <= reference_time;
		end
		if (state_q == dsop_pkg::ST_PREP) begin
			neg_q <= !time_ge;
		end
	end

	dsop_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (mag),
		.divisor   (cycle_q),
		.status    (rem_status),
		.remainder (rem_val)
	);

	// Phase error: remainder wrapped at the half cycle, or negated for a negative time.
	always_comb begin
		half = cycle_q >> 1;
		if (cycle_q == '0) begin
			err_d  = '0;
			eabs_d = '0;
			eneg_d = 1'b0;
		end else if (neg_q) begin
			err_d  = -$signed({1'b0, rem_val});
			eabs_d = rem_val;
			eneg_d = (rem_val != '0);
		end else if (rem_val > half) begin
			err_d  = $signed({1'b0, rem_val}) - $signed({1'b0, cycle_q});
			eabs_d = cycle_q - rem_val;
			eneg_d = 1'b1;
		end else begin
			err_d  = $signed({1'b0, rem_val});
			eabs_d = rem_val;
			eneg_d = 1'b0;
		end
		epos_d = !eneg_d && (eabs_d != '0);
	end

	always_ff @(posedge clk) begin
		if (state_q == dsop_pkg::ST_WRAP) begin
			err_q  <= err_d;
			eabs_q <= eabs_d;
			eneg_q <= eneg_d;
		end
	end

	// Saturating integrator, stepped by the sign of the phase error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (state_q == dsop_pkg::ST_WRAP) begin
			if (epos_d && integ_q != dsop_pkg::INT_MAX) begin
				integ_q <= integ_q + 1'b1;
			end else if (eneg_d && integ_q != dsop_pkg::INT_MIN) begin
				integ_q <= integ_q - 1'b1;
			end
		end
	end

	// Shared multiplier operand: error magnitude first, then integrator magnitude.
	assign iabs        = integ_q[dsop_pkg::INT_W-1] ? 32'(-integ_q) : 32'(integ_q);
	assign mul_operand = (mul_req.sel == dsop_pkg::MUL_INT) ? iabs : {2'b00, eabs_q};

	dsop_cmul u_cmul (
		.clk     (clk),
		.req     (mul_req),
		.operand (mul_operand),
		.product (product)
	);

	always_ff @(posedge clk) begin
		if (state_q == dsop_pkg::ST_MUL_I) begin
			qe_q   <= product[dsop_pkg::PROD_W-1:dsop_pkg::ERR_DIV_SHIFT];
			ineg_q <= integ_q[dsop_pkg::INT_W-1];
		end
	end

	// Offset is minus both signed quotients.
	always_comb begin
		qi  = product[dsop_pkg::PROD_W-1:dsop_pkg::INT_DIV_SHIFT];
		se  = dsop_pkg::OFS_W'(qe_q);
		si  = dsop_pkg::OFS_W'(qi);
		ofs = (eneg_q ? se : -se) + (ineg_q ? si : -si);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			offset_time <= $signed(ofs);
			phase_error <= err_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: design/dsop_checker.sv
// Port-level checks for the sync offset controller, bound to the top level.
`default_nettype none

module dsop_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic signed [dsop_pkg::OFS_W-1:0] offset_time,
	input  wire logic signed [dsop_pkg::PH_W-1:0]  phase_error
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(offset_time) && $stable(phase_error))
		else $error("stalled result changed");

	// Once a request is taken the block is busy in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a request was taken");

	// No result appears right after a request is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared right after acceptance");

	// The phase error stays within the signed range of PH_W-1 bits (top two bits equal).
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase_error[dsop_pkg::PH_W-1] == phase_error[dsop_pkg::PH_W-2])
		else $error("phase error out of range");

endmodule

bind dc_sync_offset_pi dsop_checker u_dsop_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.offset_time (offset_time),
	.phase_error (phase_error)
);

`default_nettype wire
